/* src/bscc_pkg.sv */
package bscc_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned INDEX_W = 3;

    typedef enum logic [INDEX_W-1:0] {
        CFG_DIRECTION  = 3'd0,
        CFG_START_CODE = 3'd1,
        CFG_END_CODE   = 3'd2,
        CFG_ESC_CODE   = 3'd3,
        CFG_START_SUB  = 3'd4,
        CFG_END_SUB    = 3'd5,
        CFG_ESC_SUB    = 3'd6
    } t_cfg_index;

    localparam logic DIR_ENCODE = 1'b0;
    localparam logic DIR_DECODE = 1'b1;

    localparam logic [BYTE_W-1:0] RST_START_CODE = 8'd141;
    localparam logic [BYTE_W-1:0] RST_END_CODE   = 8'd216;
    localparam logic [BYTE_W-1:0] RST_ESC_CODE   = 8'd171;
    localparam logic [BYTE_W-1:0] RST_START_SUB  = 8'd5;
    localparam logic [BYTE_W-1:0] RST_END_SUB    = 8'd80;
    localparam logic [BYTE_W-1:0] RST_ESC_SUB    = 8'd35;

    typedef struct packed {
        logic              direction;
        logic [BYTE_W-1:0] start_code;
        logic [BYTE_W-1:0] end_code;
        logic [BYTE_W-1:0] escape_code;
        logic [BYTE_W-1:0] start_substitute;
        logic [BYTE_W-1:0] end_substitute;
        logic [BYTE_W-1:0] escape_substitute;
    } t_cfg;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              run_last;
        logic              message_done;
        logic [BYTE_W-1:0] check_byte;
        logic              dangling_escape;
    } t_result;

    // number of results produced by one item, 0..2
    typedef logic [1:0] t_count;

endpackage

/* src/bscc_cfg.sv */
module bscc_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    input  logic [bscc_pkg::INDEX_W-1:0]  i_cfg_index,
    input  logic [bscc_pkg::BYTE_W-1:0]   i_cfg_data,
    output bscc_pkg::t_cfg                o_cfg
);
    import bscc_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_DIRECTION:  n_cfg.direction         = i_cfg_data[0];
                CFG_START_CODE: n_cfg.start_code        = i_cfg_data;
                CFG_END_CODE:   n_cfg.end_code          = i_cfg_data;
                CFG_ESC_CODE:   n_cfg.escape_code       = i_cfg_data;
                CFG_START_SUB:  n_cfg.start_substitute  = i_cfg_data;
                CFG_END_SUB:    n_cfg.end_substitute    = i_cfg_data;
                CFG_ESC_SUB:    n_cfg.escape_substitute = i_cfg_data;
                default:        n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.direction         <= DIR_ENCODE;
            r_cfg.start_code        <= RST_START_CODE;
            r_cfg.end_code          <= RST_END_CODE;
            r_cfg.escape_code       <= RST_ESC_CODE;
            r_cfg.start_substitute  <= RST_START_SUB;
            r_cfg.end_substitute    <= RST_END_SUB;
            r_cfg.escape_substitute <= RST_ESC_SUB;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* src/bscc_core.sv */
module bscc_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  bscc_pkg::t_cfg              i_cfg,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [bscc_pkg::BYTE_W-1:0] i_data_byte,
    input  logic                        i_message_last,
    input  bscc_pkg::t_count            i_free,
    output bscc_pkg::t_count            o_push_n,
    output bscc_pkg::t_result           o_res0,
    output bscc_pkg::t_result           o_res1
);
    import bscc_pkg::*;

    logic              r_a_valid;
    logic [BYTE_W-1:0] r_a_byte;
    logic              r_a_last;
    logic              r_pend;
    logic [BYTE_W-1:0] r_sum;

    logic              n_a_valid;
    logic              n_pend;
    logic [BYTE_W-1:0] n_sum;

    logic              accept;
    logic              take;
    t_count            need;
    logic              hit_s;
    logic              hit_e;
    logic              hit_x;
    logic              sub_s;
    logic              sub_e;
    logic              sub_x;
    logic [BYTE_W-1:0] sub_byte;
    logic [BYTE_W-1:0] dec_byte;
    logic [BYTE_W-1:0] add_byte;
    logic [BYTE_W-1:0] sum_add;
    logic [BYTE_W-1:0] chk;

    assign hit_s = (r_a_byte == i_cfg.start_code);
    assign hit_e = (r_a_byte == i_cfg.end_code);
    assign hit_x = (r_a_byte == i_cfg.escape_code);
    assign sub_s = (r_a_byte == i_cfg.start_substitute);
    assign sub_e = (r_a_byte == i_cfg.end_substitute);
    assign sub_x = (r_a_byte == i_cfg.escape_substitute);

    assign sub_byte = hit_s ? i_cfg.start_substitute :
                      hit_e ? i_cfg.end_substitute   : i_cfg.escape_substitute;
    assign dec_byte = sub_s ? i_cfg.start_code :
                      sub_e ? i_cfg.end_code   :
                      sub_x ? i_cfg.escape_code : r_a_byte;

    assign add_byte = (i_cfg.direction == DIR_DECODE && r_pend) ? dec_byte : r_a_byte;
    assign sum_add  = r_sum + add_byte;

    always_comb begin
        need   = 2'd1;
        o_res0 = '0;
        o_res1 = '0;
        n_sum  = r_sum;
        n_pend = r_pend;
        chk    = r_a_last ? ~sum_add : '0;
        if (i_cfg.direction == DIR_ENCODE) begin
            n_sum  = sum_add;
            n_pend = 1'b0;
            if (hit_s || hit_e || hit_x) begin
                need = 2'd2;
                o_res0.out_byte     = i_cfg.escape_code;
                o_res1.out_byte     = sub_byte;
                o_res1.run_last     = 1'b1;
                o_res1.message_done = r_a_last;
                o_res1.check_byte   = chk;
            end else begin
                o_res0.out_byte     = r_a_byte;
                o_res0.run_last     = 1'b1;
                o_res0.message_done = r_a_last;
                o_res0.check_byte   = chk;
            end
        end else if (r_pend) begin
            n_sum  = sum_add;
            n_pend = 1'b0;
            o_res0.out_byte     = dec_byte;
            o_res0.run_last     = 1'b1;
            o_res0.message_done = r_a_last;
            o_res0.check_byte   = chk;
        end else if (hit_x) begin
            if (r_a_last) begin
                o_res0.run_last        = 1'b1;
                o_res0.message_done    = 1'b1;
                o_res0.check_byte      = ~r_sum;
                o_res0.dangling_escape = 1'b1;
            end else begin
                need   = 2'd0;
                n_pend = 1'b1;
            end
        end else begin
            n_sum = sum_add;
            o_res0.out_byte     = r_a_byte;
            o_res0.run_last     = 1'b1;
            o_res0.message_done = r_a_last;
            o_res0.check_byte   = chk;
        end
        if (r_a_last) begin
            n_sum  = '0;
            n_pend = 1'b0;
        end
    end

    assign take     = r_a_valid && (need <= i_free);
    assign o_push_n = take ? need : 2'd0;
    assign o_stall  = r_a_valid && !take;
    assign accept   = i_valid && !o_stall;

    always_comb begin
        n_a_valid = r_a_valid;
        if (accept) begin
            n_a_valid = 1'b1;
        end else if (take) begin
            n_a_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_pend    <= 1'b0;
            r_sum     <= '0;
        end else begin
            r_a_valid <= n_a_valid;
            if (take) begin
                r_pend <= n_pend;
                r_sum  <= n_sum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_byte <= i_data_byte;
            r_a_last <= i_message_last;
        end
    end

`ifndef SYNTHESIS
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && r_a_last) |=> (r_sum == '0 && !r_pend))
        else $error("state not cleared after last byte");

    a_encode_no_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && i_cfg.direction == DIR_ENCODE) |=> !r_pend)
        else $error("escape pending after encode item");
`endif

endmodule

/* src/bscc_obuf.sv */
module bscc_obuf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bscc_pkg::t_count  i_push_n,
    input  bscc_pkg::t_result i_res0,
    input  bscc_pkg::t_result i_res1,
    output bscc_pkg::t_count  o_free,
    output logic              o_valid,
    input  logic              i_stall,
    output bscc_pkg::t_result o_res
);
    import bscc_pkg::*;

    t_count  r_cnt;
    t_result r_e [2];

    t_count  n_cnt;
    t_result n_e [2];

    logic    pop;
    t_count  cnt_a;

    assign o_valid = (r_cnt != 2'd0);
    assign pop     = o_valid && !i_stall;
    assign cnt_a   = r_cnt - {1'b0, pop};
    assign o_free  = 2'd2 - cnt_a;
    assign o_res   = r_e[0];

    always_comb begin
        n_e[0] = r_e[0];
        n_e[1] = r_e[1];
        if (pop) begin
            n_e[0] = r_e[1];
        end
        if (i_push_n != 2'd0) begin
            n_e[cnt_a[0]] = i_res0;
        end
        if (i_push_n == 2'd2) begin
            n_e[1] = i_res1;
        end
        n_cnt = cnt_a + i_push_n;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_e[0] <= n_e[0];
        r_e[1] <= n_e[1];
    end

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("result buffer count out of range");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push_n != 2'd0) |-> (i_push_n <= o_free))
        else $error("result buffer overflow");
`endif

endmodule

/* src/byte_stuffing_codec_checksum.sv */
// channel | dir | handshake                    | payload
// input   | in  | i_valid / o_stall            | i_data_byte, i_message_last
// result  | out | o_valid / i_stall            | o_out_byte, o_run_last, o_message_done,
//         |     |                              | o_check_byte, o_dangling_escape
// config  | in  | i_cfg_valid / o_cfg_ready    | i_cfg_index, i_cfg_data
//
// An item is held in the input register, then its results land in a
// two-entry result buffer; o_valid rises once results are in the buffer.
// One item per cycle while o_stall is low; an encoded code byte yields two
// results and so can stall the input when the output drains one result per cycle.
// Reset is synchronous; it clears the codes to defaults, the sum and the buffer.
// o_stall rises when the input register holds an item whose results do not fit.
module byte_stuffing_codec_checksum (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [bscc_pkg::BYTE_W-1:0] i_data_byte,
    input  logic                        i_message_last,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [bscc_pkg::BYTE_W-1:0] o_out_byte,
    output logic                        o_run_last,
    output logic                        o_message_done,
    output logic [bscc_pkg::BYTE_W-1:0] o_check_byte,
    output logic                        o_dangling_escape,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [bscc_pkg::INDEX_W-1:0] i_cfg_index,
    input  logic [bscc_pkg::BYTE_W-1:0] i_cfg_data
);
    import bscc_pkg::*;

    t_cfg    cfg;
    t_count  free;
    t_count  push_n;
    t_result res0;
    t_result res1;
    t_result res;

    assign o_cfg_ready = 1'b1;

    bscc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    bscc_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_data_byte    (i_data_byte),
        .i_message_last (i_message_last),
        .i_free         (free),
        .o_push_n       (push_n),
        .o_res0         (res0),
        .o_res1         (res1)
    );

    bscc_obuf u_obuf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push_n (push_n),
        .i_res0   (res0),
        .i_res1   (res1),
        .o_free   (free),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_res    (res)
    );

    assign o_out_byte        = res.out_byte;
    assign o_run_last        = res.run_last;
    assign o_message_done    = res.message_done;
    assign o_check_byte      = res.check_byte;
    assign o_dangling_escape = res.dangling_escape;

endmodule

/* tb/tb_byte_stuffing_codec_checksum.sv */
module tb_byte_stuffing_codec_checksum;
    import bscc_pkg::*;

    localparam int WATCHDOG   = 2000;
    localparam int SETTLE     = 4;
    localparam int END_SETTLE = 10;
    localparam int N_ITEMS    = 825;
    localparam int QUIET_LO   = 300;
    localparam int QUIET_HI   = 460;

    // index with no register behind it
    localparam logic [INDEX_W-1:0] CFG_UNUSED = 3'd7;

    localparam t_cfg_index CODE_REGS [6] = '{CFG_START_CODE, CFG_END_CODE, CFG_ESC_CODE,
                                             CFG_START_SUB, CFG_END_SUB, CFG_ESC_SUB};
    localparam logic [BYTE_W-1:0] CODE_RST [6] = '{RST_START_CODE, RST_END_CODE, RST_ESC_CODE,
                                                   RST_START_SUB, RST_END_SUB, RST_ESC_SUB};

    typedef struct packed {
        logic               cfg_row;
        logic [INDEX_W-1:0] idx;
        logic [BYTE_W-1:0]  data;
        logic               last;
        logic               typed;
        logic [1:0]         n_res;
        t_result            res0;
        t_result            res1;
    } t_row;

    localparam t_result NO_RES = '0;
    localparam logic [BYTE_W-1:0] ENC = {7'd0, DIR_ENCODE};
    localparam logic [BYTE_W-1:0] DEC = {7'd0, DIR_DECODE};

    localparam int N_DIRECTED = 35;
    localparam t_row DIRECTED [N_DIRECTED] = '{
        // reset codes, encode
        '{1'b0, CFG_DIRECTION, 8'h00, 1'b0, 1'b1, 2'd1,
          '{8'h00, 1'b1, 1'b0, 8'h00, 1'b0}, NO_RES},
        '{1'b0, CFG_DIRECTION, 8'hFF, 1'b0, 1'b1, 2'd1,
          '{8'hFF, 1'b1, 1'b0, 8'h00, 1'b0}, NO_RES},
        '{1'b0, CFG_DIRECTION, RST_START_CODE, 1'b0, 1'b1, 2'd2,
          '{RST_ESC_CODE, 1'b0, 1'b0, 8'h00, 1'b0},
          '{RST_START_SUB, 1'b1, 1'b0, 8'h00, 1'b0}},
        '{1'b0, CFG_DIRECTION, RST_END_CODE, 1'b1, 1'b1, 2'd2,
          '{RST_ESC_CODE, 1'b0, 1'b0, 8'h00, 1'b0},
          '{RST_END_SUB, 1'b1, 1'b1, 8'd155, 1'b0}},
        '{1'b0, CFG_DIRECTION, RST_ESC_CODE, 1'b1, 1'b1, 2'd2,
          '{RST_ESC_CODE, 1'b0, 1'b0, 8'h00, 1'b0},
          '{RST_ESC_SUB, 1'b1, 1'b1, 8'd84, 1'b0}},
        '{1'b1, CFG_DIRECTION, DEC, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
        // escape on last byte, then a swallowed escape
        '{1'b0, CFG_DIRECTION, RST_ESC_CODE, 1'b1, 1'b1, 2'd1,
          '{8'h00, 1'b1, 1'b1, 8'hFF, 1'b1}, NO_RES},
        '{1'b0, CFG_DIRECTION, RST_ESC_CODE, 1'b0, 1'b1, 2'd0, NO_RES, NO_RES},
        '{1'b0, CFG_DIRECTION, RST_START_SUB, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
        '{1'b0, CFG_DIRECTION, RST_ESC_CODE, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
        '{1'b0, CFG_DIRECTION, RST_END_SUB, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
        '{1'b0, CFG_DIRECTION, RST_ESC_CODE, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
        '{1'b0, CFG_DIRECTION, RST_ESC_SUB, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
        // follower equal to escape code is data
        '{1'b0, CFG_DIRECTION, RST_ESC_CODE, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
        '{1'b0, CFG_DIRECTION, RST_ESC_CODE, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
        // unknown follower
        '{1'b0, CFG_DIRECTION, RST_ESC_CODE, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
        '{1'b0, CFG_DIRECTION, 8'hFF, 1'b1, 1'b0, 2'd0, NO_RES, NO_RES},
        '{1'b0, CFG_DIRECTION, 8'h00, 1'b1, 1'b1, 2'd1,
          '{8'h00, 1'b1, 1'b1, 8'hFF, 1'b0}, NO_RES},
        // direction flips to encode with an escape pending
        '{1'b0, CFG_DIRECTION, RST_ESC_CODE, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
        '{1'b1, CFG_DIRECTION, ENC, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
        '{1'b0, CFG_DIRECTION, RST_ESC_CODE, 1'b1, 1'b0, 2'd0, NO_RES, NO_RES},
        // overlapping codes and substitutes, extremes
        '{1'b1, CFG_START_CODE, 8'h00, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
        '{1'b1, CFG_END_CODE, 8'h00, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
        '{1'b1, CFG_ESC_CODE, 8'hFF, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
        '{1'b1, CFG_START_SUB, 8'hFF, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
        '{1'b1, CFG_END_SUB, 8'hFF, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
        '{1'b1, CFG_ESC_SUB, 8'h00, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
        '{1'b1, CFG_UNUSED, 8'h5A, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
        '{1'b0, CFG_DIRECTION, 8'h00, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
        '{1'b0, CFG_DIRECTION, 8'hFF, 1'b1, 1'b0, 2'd0, NO_RES, NO_RES},
        '{1'b1, CFG_DIRECTION, DEC, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
        '{1'b0, CFG_DIRECTION, 8'hFF, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
        '{1'b0, CFG_DIRECTION, 8'hFF, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
        '{1'b0, CFG_DIRECTION, 8'hFF, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
        '{1'b0, CFG_DIRECTION, 8'h00, 1'b1, 1'b0, 2'd0, NO_RES, NO_RES}
    };

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic [BYTE_W-1:0]  i_data_byte;
    logic               i_message_last;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic [BYTE_W-1:0]  o_out_byte;
    logic               o_run_last;
    logic               o_message_done;
    logic [BYTE_W-1:0]  o_check_byte;
    logic               o_dangling_escape;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [INDEX_W-1:0] i_cfg_index;
    logic [BYTE_W-1:0]  i_cfg_data;

    t_cfg              codec_cfg;
    logic              esc_seen;
    logic [BYTE_W-1:0] byte_sum;
    t_result           due_results [$];
    t_result           step_results [$];
    t_result           typed_results [$];
    logic              typed_on = 1'b0;
    logic [8:0]        msg_bytes [$];
    int                bytes_in = 0;
    int                err_cnt = 0;
    int                idle_cnt = 0;

    byte_stuffing_codec_checksum u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_data_byte      (i_data_byte),
        .i_message_last   (i_message_last),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_out_byte       (o_out_byte),
        .o_run_last       (o_run_last),
        .o_message_done   (o_message_done),
        .o_check_byte     (o_check_byte),
        .o_dangling_escape(o_dangling_escape),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic idling_on();
        return bytes_in < QUIET_LO || bytes_in >= QUIET_HI;
    endfunction

    function automatic t_result make_res(input logic [BYTE_W-1:0] b, input logic run,
                                         input logic done, input logic dangling);
        t_result r;
        r.out_byte        = b;
        r.run_last        = run;
        r.message_done    = done;
        r.check_byte      = done ? ~byte_sum : 8'h00;
        r.dangling_escape = dangling;
        return r;
    endfunction

    function automatic void stuff_step(input logic [BYTE_W-1:0] b, input logic last);
        logic [BYTE_W-1:0] v;
        step_results.delete();
        if (codec_cfg.direction == DIR_ENCODE) begin
            esc_seen = 1'b0;
            byte_sum = byte_sum + b;
            if (b == codec_cfg.start_code || b == codec_cfg.end_code
                    || b == codec_cfg.escape_code) begin
                if (b == codec_cfg.start_code) v = codec_cfg.start_substitute;
                else if (b == codec_cfg.end_code) v = codec_cfg.end_substitute;
                else v = codec_cfg.escape_substitute;
                step_results.push_back(make_res(codec_cfg.escape_code, 1'b0, 1'b0, 1'b0));
                step_results.push_back(make_res(v, 1'b1, last, 1'b0));
            end else begin
                step_results.push_back(make_res(b, 1'b1, last, 1'b0));
            end
        end else if (esc_seen) begin
            if (b == codec_cfg.start_substitute) v = codec_cfg.start_code;
            else if (b == codec_cfg.end_substitute) v = codec_cfg.end_code;
            else if (b == codec_cfg.escape_substitute) v = codec_cfg.escape_code;
            else v = b;
            esc_seen = 1'b0;
            byte_sum = byte_sum + v;
            step_results.push_back(make_res(v, 1'b1, last, 1'b0));
        end else if (b == codec_cfg.escape_code) begin
            if (last) step_results.push_back(make_res(8'h00, 1'b1, 1'b1, 1'b1));
            else esc_seen = 1'b1;
        end else begin
            byte_sum = byte_sum + b;
            step_results.push_back(make_res(b, 1'b1, last, 1'b0));
        end
        if (last) begin
            byte_sum = 8'h00;
            esc_seen = 1'b0;
        end
    endfunction

    task automatic report_err(input string what, input logic [BYTE_W-1:0] got,
                              input logic [BYTE_W-1:0] want);
        err_cnt++;
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $time);
    endtask

    task automatic send_item(input logic [BYTE_W-1:0] d, input logic last);
        while (idling_on() && $urandom_range(99) < 37) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid        <= 1'b1;
        i_data_byte    <= d;
        i_message_last <= last;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        stuff_step(d, last);
        if (typed_on) begin
            foreach (typed_results[j]) due_results.push_back(typed_results[j]);
        end else begin
            foreach (step_results[j]) due_results.push_back(step_results[j]);
        end
        bytes_in++;
        @(negedge i_clk);
    endtask

    task automatic drain_wait(input int settle);
        i_valid <= 1'b0;
        @(negedge i_clk);
        while (due_results.size() != 0) @(negedge i_clk);
        repeat (settle) @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic [INDEX_W-1:0] idx, input logic [BYTE_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_DIRECTION:  codec_cfg.direction         = val[0];
            CFG_START_CODE: codec_cfg.start_code        = val;
            CFG_END_CODE:   codec_cfg.end_code          = val;
            CFG_ESC_CODE:   codec_cfg.escape_code       = val;
            CFG_START_SUB:  codec_cfg.start_substitute  = val;
            CFG_END_SUB:    codec_cfg.end_substitute    = val;
            CFG_ESC_SUB:    codec_cfg.escape_substitute = val;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic random_config();
        logic [BYTE_W-1:0] v;
        cfg_write(CFG_DIRECTION, 8'($urandom));
        for (int i = 0; i < 6; i++) begin
            if ($urandom_range(99) < 60) begin
                case ($urandom_range(9))
                    0, 1, 2: v = CODE_RST[i];
                    3:       v = 8'h00;
                    4:       v = 8'hFF;
                    5:       v = codec_cfg.escape_code;
                    6:       v = codec_cfg.start_code;
                    default: v = 8'($urandom);
                endcase
                cfg_write(CODE_REGS[i], v);
            end
        end
        if ($urandom_range(99) < 10) cfg_write(CFG_UNUSED, 8'($urandom));
    endtask

    function automatic logic [BYTE_W-1:0] pick_byte();
        case ($urandom_range(11))
            0:       return codec_cfg.start_code;
            1:       return codec_cfg.end_code;
            2:       return codec_cfg.escape_code;
            3:       return codec_cfg.start_substitute;
            4:       return codec_cfg.end_substitute;
            5:       return codec_cfg.escape_substitute;
            6:       return 8'h00;
            7:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    // decode messages are mostly properly stuffed, with some raw noise
    function automatic void build_message(input logic ends);
        int len;
        logic [BYTE_W-1:0] b;
        msg_bytes.delete();
        len = ($urandom_range(99) < 5) ? $urandom_range(20, 40) : $urandom_range(1, 10);
        for (int k = 0; k < len; k++) begin
            b = pick_byte();
            if (codec_cfg.direction == DIR_ENCODE || $urandom_range(99) < 8) begin
                msg_bytes.push_back({1'b0, b});
            end else if (b == codec_cfg.start_code) begin
                msg_bytes.push_back({1'b0, codec_cfg.escape_code});
                msg_bytes.push_back({1'b0, codec_cfg.start_substitute});
            end else if (b == codec_cfg.end_code) begin
                msg_bytes.push_back({1'b0, codec_cfg.escape_code});
                msg_bytes.push_back({1'b0, codec_cfg.end_substitute});
            end else if (b == codec_cfg.escape_code) begin
                msg_bytes.push_back({1'b0, codec_cfg.escape_code});
                msg_bytes.push_back({1'b0, codec_cfg.escape_substitute});
            end else begin
                msg_bytes.push_back({1'b0, b});
            end
        end
        if (codec_cfg.direction == DIR_DECODE && $urandom_range(99) < 6)
            msg_bytes.push_back({1'b0, codec_cfg.escape_code});
        if (ends) msg_bytes[msg_bytes.size()-1][8] = 1'b1;
    endfunction

    always @(negedge i_clk) begin
        i_stall <= idling_on() && ($urandom_range(99) < 37);
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (due_results.size() == 0) begin
                report_err("result with nothing pending", o_out_byte, 8'h00);
            end else begin
                want = due_results.pop_front();
                if (o_out_byte !== want.out_byte)
                    report_err("out_byte", o_out_byte, want.out_byte);
                if (o_run_last !== want.run_last)
                    report_err("run_last", 8'(o_run_last), 8'(want.run_last));
                if (o_message_done !== want.message_done)
                    report_err("message_done", 8'(o_message_done), 8'(want.message_done));
                if (o_check_byte !== want.check_byte)
                    report_err("check_byte", o_check_byte, want.check_byte);
                if (o_dangling_escape !== want.dangling_escape)
                    report_err("dangling_escape", 8'(o_dangling_escape),
                               8'(want.dangling_escape));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)
                || (i_cfg_valid && o_cfg_ready)) begin
            idle_cnt <= 0;
        end else if (idle_cnt >= WATCHDOG) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            idle_cnt <= idle_cnt + 1;
        end
    end

    initial begin
        int   n_msg;
        logic held;
        codec_cfg = '{DIR_ENCODE, RST_START_CODE, RST_END_CODE, RST_ESC_CODE,
                      RST_START_SUB, RST_END_SUB, RST_ESC_SUB};
        esc_seen  = 1'b0;
        byte_sum  = 8'h00;
        held      = 1'b0;
        i_rst_n        <= 1'b0;
        i_valid        <= 1'b0;
        i_data_byte    <= 8'h00;
        i_message_last <= 1'b0;
        i_cfg_valid    <= 1'b0;
        i_cfg_index    <= CFG_DIRECTION;
        i_cfg_data     <= 8'h00;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int r = 0; r < N_DIRECTED; r++) begin
            if (DIRECTED[r].cfg_row) begin
                if (r == 0 || !DIRECTED[r-1].cfg_row) drain_wait(SETTLE);
                cfg_write(DIRECTED[r].idx, DIRECTED[r].data);
            end else begin
                typed_results.delete();
                if (DIRECTED[r].n_res > 0) typed_results.push_back(DIRECTED[r].res0);
                if (DIRECTED[r].n_res > 1) typed_results.push_back(DIRECTED[r].res1);
                typed_on = DIRECTED[r].typed;
                send_item(DIRECTED[r].data, DIRECTED[r].last);
                typed_on = 1'b0;
            end
        end

        while (bytes_in < N_ITEMS) begin
            drain_wait(SETTLE);
            random_config();
            n_msg = $urandom_range(2, 8);
            for (int m = 0; m < n_msg; m++) begin
                build_message(m != n_msg - 1 || $urandom_range(99) >= 10);
                foreach (msg_bytes[j]) send_item(msg_bytes[j][7:0], msg_bytes[j][8]);
                if (!held || $urandom_range(99) < 3) begin
                    held = 1'b1;
                    drain_wait(0);
                end
            end
        end

        drain_wait(END_SETTLE);
        if (due_results.size() != 0)
            report_err("results never arrived", 8'(due_results.size()), 8'h00);
        if (err_cnt == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

/* byte_stuffing_codec_checksum.f */
src/bscc_pkg.sv
src/bscc_cfg.sv
src/bscc_core.sv
src/bscc_obuf.sv
src/byte_stuffing_codec_checksum.sv
tb/tb_byte_stuffing_codec_checksum.sv
